FILE: hdl/lcb_pkg.sv
`default_nettype none
package lcb_pkg;

  typedef enum logic [1:0] {
    KIND_OFFER = 2'd0,
    KIND_MERGE = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  localparam int unsigned CfgW      = 4;
  localparam int unsigned CfgReset  = 12;
  localparam int unsigned HashW     = 32;
  localparam int unsigned ByteIdxW  = 12;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned NewBitsW  = 4;
  localparam int unsigned ZerosW    = 16;

  typedef struct packed {
    logic busy;
    logic last;
  } sweep_stat_t;

  function automatic logic [NewBitsW-1:0] pop8(input logic [ByteW-1:0] v);
    logic [NewBitsW-1:0] n;
    n = '0;
    for (int k = 0; k < ByteW; k++) begin
      n = n + NewBitsW'(v[k]);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/linear_counting_bitmap.sv
`default_nettype none
// An input beat is registered into stage 1 with its RAM read; stage 1 then modifies and
// writes the byte back and loads the result register. Throughput: one offer or merge beat
// per cycle while the output is not stalled; same-byte back-to-back beats forward.
// A clear beat blocks input until it retires and then while the bytes in use are zeroed.
// Reset: async, active low; bitmap_log2_bytes returns to 12 and a clearing pass over all
// 2^MAX_LOG2_BYTES bytes runs before the first input beat is taken.
module linear_counting_bitmap #(
  parameter int unsigned MAX_LOG2_BYTES = 12
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [lcb_pkg::CfgW-1:0]      cfg_bitmap_log2_bytes_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    kind_i,
  input  wire logic [lcb_pkg::HashW-1:0]     hash_value_i,
  input  wire logic [lcb_pkg::ByteIdxW-1:0]  byte_index_i,
  input  wire logic [lcb_pkg::ByteW-1:0]     byte_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [lcb_pkg::NewBitsW-1:0]  new_bits_o,
  output logic      [lcb_pkg::ZerosW-1:0]    zeros_left_o
);
  import lcb_pkg::*;

  localparam int unsigned AW      = MAX_LOG2_BYTES;
  localparam int unsigned DEPTH   = 1 << MAX_LOG2_BYTES;
  localparam int unsigned CNT_W   = MAX_LOG2_BYTES + 4;
  localparam int unsigned LW      = 5;
  localparam int unsigned RST_L   = (CfgReset > MAX_LOG2_BYTES) ? MAX_LOG2_BYTES : CfgReset;
  localparam logic [CNT_W-1:0] RST_CNT = CNT_W'(8) << RST_L;

  // configuration
  logic [CfgW-1:0] cfg_q;
  logic [LW-1:0]   l_use;
  logic [AW-1:0]   amask;
  logic [CNT_W-1:0] bits_in_use;

  assign cfg_ready_o = 1'b1;
  assign l_use = (32'(cfg_q) > MAX_LOG2_BYTES) ? LW'(MAX_LOG2_BYTES) : LW'(cfg_q);
  assign amask = ~({AW{1'b1}} << l_use);
  assign bits_in_use = CNT_W'(8) << l_use;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgW'(CfgReset);
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_bitmap_log2_bytes_i;
    end
  end

  // input decode
  kind_e         in_kind;
  logic [AW-1:0] in_addr;
  logic [ByteW-1:0] in_opb;
  logic [31:0]   bidx_ext;
  logic [2:0]    bit_sel;

  assign in_kind  = kind_e'(kind_i);
  assign bidx_ext = 32'(byte_index_i);
  assign bit_sel  = hash_value_i[2:0];

  always_comb begin
    in_addr = '0;
    in_opb  = '0;
    case (in_kind)
      KIND_OFFER: begin
        in_addr = hash_value_i[3 +: AW] & amask;
        in_opb  = ByteW'(1) << bit_sel;
      end
      KIND_MERGE: begin
        in_addr = bidx_ext[AW-1:0] & amask;
        in_opb  = byte_value_i;
      end
      default: begin
        in_addr = '0;
        in_opb  = '0;
      end
    endcase
  end

  // stage 1: modify and write back
  logic          s1_v_q;
  kind_e         s1_kind_q;
  logic [AW-1:0] s1_addr_q;
  logic [ByteW-1:0] s1_opb_q;
  logic          fwd_hit_q;
  logic [ByteW-1:0] fwd_q;
  logic [ByteW-1:0] rdata;
  logic [ByteW-1:0] cur;
  logic [ByteW-1:0] new_byte;
  logic [NewBitsW-1:0] fresh;
  logic          s1_writes;
  logic          s1_fire;
  logic          in_fire;
  logic          out_v_q;
  logic [NewBitsW-1:0] new_bits_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  sweep_stat_t   sweep;
  logic [AW-1:0] sweep_addr;

  assign cur       = fwd_hit_q ? fwd_q : rdata;
  assign new_byte  = cur | s1_opb_q;
  assign fresh     = pop8(s1_opb_q & ~cur);
  assign s1_writes = (s1_kind_q == KIND_OFFER) || (s1_kind_q == KIND_MERGE);
  assign s1_fire   = s1_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !sweep.busy && !(s1_v_q && s1_kind_q == KIND_CLEAR)
                      && (!s1_v_q || s1_fire);
  assign in_fire   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_fire) begin
      s1_v_q <= 1'b1;
    end else if (s1_fire) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (in_fire) begin
      fwd_hit_q <= s1_fire && s1_writes && (s1_addr_q == in_addr);
    end else if (s1_fire) begin
      fwd_hit_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q <= in_kind;
      s1_addr_q <= in_addr;
      s1_opb_q  <= in_opb;
      fwd_q     <= new_byte;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (s1_fire) begin
      if (s1_kind_q == KIND_CLEAR) begin
        cnt_d = bits_in_use;
      end else if (s1_writes) begin
        cnt_d = (cnt_q > CNT_W'(fresh)) ? cnt_q - CNT_W'(fresh) : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= RST_CNT;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // result register
  logic [31:0] cnt_ext;
  assign cnt_ext = 32'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_fire) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      new_bits_q <= s1_writes ? fresh : '0;
    end
  end

  assign out_valid_o  = out_v_q;
  assign new_bits_o   = new_bits_q;
  assign zeros_left_o = cnt_ext[ZerosW-1:0];

  // clear sweep
  lcb_sweep #(
    .AW(AW)
  ) u_sweep (
    .clk_i,
    .rst_ni,
    .start_i    (s1_fire && s1_kind_q == KIND_CLEAR),
    .end_addr_i (amask),
    .stat_o     (sweep),
    .addr_o     (sweep_addr)
  );

  // bitmap store
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [ByteW-1:0] ram_wdata;

  assign ram_we    = sweep.busy || (s1_fire && s1_writes);
  assign ram_waddr = sweep.busy ? sweep_addr : s1_addr_q;
  assign ram_wdata = sweep.busy ? '0 : new_byte;

  lcb_ram #(
    .WIDTH(ByteW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (in_addr),
    .rdata_o (rdata)
  );

  a_sweep_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep.busy |-> !in_ready_o)
    else $error("input accepted during clear sweep");

  a_fwd_needs_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> s1_v_q)
    else $error("forward flag without stage 1 item");

  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_kind_q == KIND_CLEAR) |=> (sweep.busy && new_bits_o == '0))
    else $error("clear did not start sweep");

  a_sweep_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep.busy |-> !s1_v_q || s1_kind_q == KIND_CLEAR)
    else $error("item in flight during sweep");

endmodule
`default_nettype wire

FILE: hdl/lcb_ram.sv
`default_nettype none
module lcb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: hdl/lcb_sweep.sv
`default_nettype none
module lcb_sweep #(
  parameter int unsigned AW = 12
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [AW-1:0]        end_addr_i,
  output lcb_pkg::sweep_stat_t      stat_o,
  output logic      [AW-1:0]        addr_o
);
  import lcb_pkg::*;

  logic          busy_q, busy_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] end_q, end_d;
  logic          last;

  assign last = (addr_q == end_q);

  always_comb begin
    busy_d = busy_q;
    addr_d = addr_q;
    end_d  = end_q;
    if (busy_q) begin
      addr_d = addr_q + AW'(1);
      if (last) begin
        busy_d = 1'b0;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      addr_d = '0;
      end_d  = end_addr_i;
    end
  end

  // reset starts a pass over the whole store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      addr_q <= '0;
      end_q  <= '1;
    end else begin
      busy_q <= busy_d;
      addr_q <= addr_d;
      end_q  <= end_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.last = last;
  assign addr_o      = addr_q;

endmodule
`default_nettype wire
